@@ hdl/l8mwc_pkg.sv @@
// Shared constants and types for the lag-8 multiply-with-carry generator.
package l8mwc_pkg;

	localparam int WORD_W  = 16;
	localparam int SEED_W  = 64;
	localparam int VALUE_W = 32;
	localparam int LAG_N   = 8;
	localparam int POS_W   = 3;
	localparam int SCR_ROT = 7;

	localparam logic [WORD_W-1:0] MWC_MULT = 16'd59814;
	localparam logic [WORD_W-1:0] SCR_MULT = 16'd62517;
	localparam logic [WORD_W-1:0] CARRY_RST = 16'd1;

	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef struct packed {
		logic reseed;    // load lag words from the seed
		logic step;      // run one MWC sub-step
		logic hi_cap;    // capture scrambled upper half
		logic load_out;  // load the output register
	} l8mwc_cmd_t;

endpackage

@@ hdl/l8mwc_req_if.sv @@
// Input channel: valid/ready handshake carrying kind and seed.
interface l8mwc_req_if;
	import l8mwc_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [SEED_W-1:0] seed;

	modport source(output valid, output kind, output seed, input ready);
	modport sink(input valid, input kind, input seed, output ready);
endinterface

@@ hdl/l8mwc_rsp_if.sv @@
// Output channel: valid/ready handshake carrying the 32-bit value.
interface l8mwc_rsp_if;
	import l8mwc_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

@@ hdl/l8mwc_dp.sv @@
// Datapath: lag words, carry, position, MWC multiplier and output scrambler.
module l8mwc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  l8mwc_pkg::l8mwc_cmd_t         cmd,
	input  logic [l8mwc_pkg::SEED_W-1:0]  seed,
	output logic [l8mwc_pkg::VALUE_W-1:0] value
);
	import l8mwc_pkg::*;

	logic [WORD_W-1:0]   words_q [LAG_N];
	logic [WORD_W-1:0]   carry_q;
	logic [POS_W-1:0]    pos_q;
	logic [WORD_W-1:0]   prev_q;    // always equals words_q[pos_q]

	logic [WORD_W-1:0]   nw_s1;
	logic [WORD_W-1:0]   rot_s1;
	logic [WORD_W-1:0]   hi_q;
	logic [VALUE_W-1:0]  value_q;

	logic [POS_W-1:0]    npos;
	logic [2*WORD_W-1:0] prod;
	logic [2*WORD_W-1:0] scr_prod;
	logic [WORD_W-1:0]   scr;

	assign npos = pos_q + POS_W'(1);
	assign prod = 32'(MWC_MULT) * 32'(words_q[npos]) + 32'(carry_q);

	// Scrambler works on the registered sub-step result
	assign scr_prod = 32'(SCR_MULT) * 32'(nw_s1);
	assign scr      = scr_prod[WORD_W-1:0] ^ rot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAG_N; i++) begin
				words_q[i] <= WORD_W'(i);
			end
			carry_q <= CARRY_RST;
			pos_q   <= '0;
			prev_q  <= '0;
		end else if (cmd.reseed) begin
			for (int i = 0; i < LAG_N; i++) begin
				words_q[i] <= seed[WORD_W*(i % 4) +: WORD_W] + WORD_W'(i);
			end
			carry_q <= CARRY_RST;
			pos_q   <= '0;
			prev_q  <= seed[WORD_W-1:0];
		end else if (cmd.step) begin
			words_q[npos] <= prod[WORD_W-1:0];
			carry_q       <= prod[2*WORD_W-1:WORD_W];
			pos_q         <= npos;
			prev_q        <= prod[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			nw_s1  <= prod[WORD_W-1:0];
			rot_s1 <= {prev_q[WORD_W-1-SCR_ROT:0], prev_q[WORD_W-1:WORD_W-SCR_ROT]};
		end
		if (cmd.hi_cap) begin
			hi_q <= scr;
		end
		if (cmd.load_out) begin
			value_q <= {hi_q, scr};
		end
	end

	assign value = value_q;

endmodule

@@ hdl/l8mwc_ctrl.sv @@
// Controller: sequences the two sub-steps of a draw and owns the output valid.
module l8mwc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_kind,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	output l8mwc_pkg::l8mwc_cmd_t cmd
);
	import l8mwc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUB1 = 2'd1;
	localparam logic [1:0] ST_SUB2 = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       in_acc;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_kind == KIND_SEED) begin
					cmd.reseed = 1'b1;
				end else if (in_acc && in_kind == KIND_DRAW) begin
					state_d = ST_SUB1;
				end
			end
			ST_SUB1: begin
				cmd.step = 1'b1;
				state_d  = ST_SUB2;
			end
			ST_SUB2: begin
				cmd.step   = 1'b1;
				cmd.hi_cap = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_draw_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_kind == KIND_DRAW |=> state_q == ST_SUB1)
		else $error("draw beat did not start sub-step one");

	a_sub_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUB1 |=> state_q == ST_SUB2 && $past(cmd.step))
		else $error("sub-step two did not follow sub-step one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || out_ready)
		else $error("output overwritten while still pending");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output valid raised outside finish state");
`endif

endmodule

@@ hdl/lag8_mwc16_prng.sv @@
// Top level of the lag-8 multiply-with-carry 16-bit random generator.
// Lag-8 multiply-with-carry generator over 16-bit words with a scrambled output.
// A beat on req with kind = 0 reseeds: carry = 1, position = 0, and lag word i
// = seed slice (i mod 4) + i; it produces no rsp beat. A beat with kind = 1 draws
// one 32-bit value: two dependent MWC sub-steps run on one 16x16 multiplier (one
// sub-step per cycle), each followed by a 16-bit scramble multiply of the
// registered sub-step result. A draw passes the sub-step 1, sub-step 2 and finish
// states before loading the output register, and waits in finish while a previous
// value is still waiting on rsp. The first sub-step's 16 bits form the upper half
// of value. req is taken whenever the sequencer is idle, even while a finished
// value waits on rsp. Reset restores word i = i, carry = 1, position = 0.
module lag8_mwc16_prng (
	input  logic         clk,
	input  logic         arst_n,
	l8mwc_req_if.sink    req,
	l8mwc_rsp_if.source  rsp
);
	import l8mwc_pkg::*;

	l8mwc_cmd_t cmd;

	// Sequencer: idle / sub-step 1 / sub-step 2 / finish
	l8mwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_kind   (req.kind),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	// Lag state, MWC multiplier and scrambler
	l8mwc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.seed   (req.seed),
		.value  (rsp.value)
	);

endmodule
